// File: rtl/lcgkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgkd_pkg
// Types, constants and the block order table shared by the keystream record
// decoder.
// ----------------------------------------------------------------------------
package lcgkd_pkg;

    localparam logic [31:0] LCG_MUL    = 32'h41C6_4E6D;
    localparam logic [31:0] LCG_ADD    = 32'h0000_6073;
    localparam logic [7:0]  HEAD_WORDS = 8'd4;
    localparam logic [7:0]  BLK_WORDS  = 8'd28;
    localparam logic [7:0]  KEY_HI_POS = 8'd1;
    localparam logic [7:0]  CSUM_POS   = 8'd3;
    localparam logic [7:0]  BODY_LAST  = 8'd115;
    localparam logic [7:0]  TAIL_FIRST = 8'd116;
    localparam logic [7:0]  PARTY_LAST = 8'd129;
    localparam logic [4:0]  ORDER_MOD  = 5'd24;

    // Output block i holds input block ORDER_TBL[t][i].
    localparam logic [1:0] ORDER_TBL [0:23][0:3] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd2, 2'd3, 2'd1, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    typedef struct packed {
        logic [15:0] data_word;
        logic        record_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_word;
        logic [7:0]  out_index;
        logic        check_valid;
        logic        check_ok;
        logic        record_end;
    } t_out_item;

    typedef struct packed {
        logic [31:0] generator_state;
        logic [31:0] key_value;
        logic [7:0]  word_position;
        logic [15:0] running_sum;
        logic [15:0] stored_sum;
        logic [4:0]  order_select;
    } t_dec_state;

    // Output block that receives input block src under order t.
    function automatic logic [1:0] dest_block(input logic [4:0] t, input logic [1:0] src);
        logic [1:0] result;
        result = src;
        for (int i = 3; i >= 0; i--) begin
            if (ORDER_TBL[t][i] == src) begin
                result = 2'(i);
            end
        end
        return result;
    endfunction

endpackage

// File: rtl/lcgkd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgkd_core
// Decoder state and the combinational step: position tracking, LCG advance,
// XOR decryption, checksum and unshuffled index for one word.
// ----------------------------------------------------------------------------
module lcgkd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_party,
    input  lcgkd_pkg::t_in_item  i_item,
    output lcgkd_pkg::t_out_item o_result
);
    import lcgkd_pkg::*;

    t_dec_state r_st;
    t_dec_state n_st;

    logic [7:0]  pos_raw;
    logic [7:0]  pos;
    logic [31:0] seed;
    logic [31:0] prod;
    logic [31:0] lcg_next;
    logic [15:0] dec_word;
    logic [15:0] sum_next;
    logic [6:0]  rel;
    logic [1:0]  blk;
    logic [6:0]  blk_base;
    logic [4:0]  off;
    logic [4:0]  order_t;
    logic [1:0]  dest;
    logic        is_end;

    assign pos_raw = i_item.record_start ? 8'd0 : r_st.word_position;
    assign pos     = (pos_raw > PARTY_LAST) ? 8'd0 : pos_raw;

    // The tail restarts the generator from the key on its first word.
    assign seed     = (pos == TAIL_FIRST) ? r_st.key_value : r_st.generator_state;
    assign prod     = seed * LCG_MUL;
    assign lcg_next = prod + LCG_ADD;
    assign dec_word = i_item.data_word ^ lcg_next[31:16];
    assign sum_next = r_st.running_sum + dec_word;

    assign rel = 7'(pos - HEAD_WORDS);
    always_comb begin
        if (rel >= 7'd84) begin
            blk = 2'd3;
            blk_base = 7'd84;
        end else if (rel >= 7'd56) begin
            blk = 2'd2;
            blk_base = 7'd56;
        end else if (rel >= 7'd28) begin
            blk = 2'd1;
            blk_base = 7'd28;
        end else begin
            blk = 2'd0;
            blk_base = 7'd0;
        end
    end
    assign off     = 5'(rel - blk_base);
    assign order_t = (r_st.order_select >= ORDER_MOD) ? r_st.order_select - ORDER_MOD
                                                      : r_st.order_select;
    assign dest    = dest_block(order_t, blk);

    always_comb begin
        n_st     = r_st;
        o_result = '0;
        o_result.out_word  = i_item.data_word;
        o_result.out_index = pos;
        is_end = 1'b0;
        if (pos < HEAD_WORDS) begin
            if (pos == 8'd0) begin
                n_st.key_value   = {16'd0, i_item.data_word};
                n_st.running_sum = 16'd0;
            end else if (pos == KEY_HI_POS) begin
                n_st.key_value       = {i_item.data_word, r_st.key_value[15:0]};
                n_st.generator_state = {i_item.data_word, r_st.key_value[15:0]};
                n_st.order_select    = i_item.data_word[1:0] == 2'b00 ?
                                       {i_item.data_word[1:0], r_st.key_value[15:13]} :
                                       {i_item.data_word[1:0], r_st.key_value[15:13]};
            end else if (pos == CSUM_POS) begin
                n_st.stored_sum = i_item.data_word;
            end
        end else if (pos <= BODY_LAST) begin
            n_st.generator_state = lcg_next;
            n_st.running_sum     = sum_next;
            o_result.out_word    = dec_word;
            o_result.out_index   = HEAD_WORDS + BLK_WORDS * {6'd0, dest} + {3'd0, off};
            if (pos == BODY_LAST) begin
                o_result.check_valid = 1'b1;
                o_result.check_ok    = (sum_next == r_st.stored_sum);
                is_end = !i_party;
            end
        end else begin
            n_st.generator_state = lcg_next;
            o_result.out_word    = dec_word;
            is_end = (pos == PARTY_LAST);
        end
        o_result.record_end = is_end;
        n_st.word_position  = is_end ? 8'd0 : pos + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

endmodule

// File: rtl/lcg_keystream_record_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Each input transfer passes through the input register, then the result
// register. Throughput: one word per cycle while the output is not stalled,
// set by the LCG multiply-add recurrence.
// Reset is synchronous and active low; it clears the decoder state, the
// record length setting and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
// lcg_keystream_record_decoder_top
// Decodes a record of 16-bit words: header pass-through, LCG XOR keystream,
// block unshuffling of the body and checksum flag on the last body word.
// ----------------------------------------------------------------------------
module lcg_keystream_record_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcgkd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcgkd_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);
    import lcgkd_pkg::*;

    logic      r_party;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item step_result;
    logic      step_fire;

    // The input register holds its word while a result waits downstream.
    assign step_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step_fire;

    lcgkd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (step_fire),
        .i_party  (r_party),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_party <= 1'b0;
        end else if (i_cfg_we) begin
            r_party <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // The last body word always lands at the last offset of some block.
    a_check_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.check_valid) |->
        (r_out_item.out_index == 8'd31 || r_out_item.out_index == 8'd59 ||
         r_out_item.out_index == 8'd87 || r_out_item.out_index == 8'd115))
        else $error("check flag on a word outside a block end");

    a_ok_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.check_valid) |-> !r_out_item.check_ok)
        else $error("check_ok raised without check_valid");

    a_end_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.record_end) |->
        (r_out_item.check_valid || r_out_item.out_index == PARTY_LAST))
        else $error("record end on an unexpected word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keystream record decoder. Records are sent as
// word streams with random idling on both channels, and every result is
// compared field by field against a predictor that tracks the key, generator,
// position, checksum and record length setting. Directed tests cover header
// extremes, tail records, start marks, wrap-around starts and length changes
// part-way through a record, followed by a random run.
// ----------------------------------------------------------------------------
module tb_top;
    import lcgkd_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int HOLD_CYCLES  = 150;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    lcg_keystream_record_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted decoder state
    logic [31:0] gen_state   = '0;
    logic [31:0] key_reg     = '0;
    logic [7:0]  next_pos    = '0;
    logic [15:0] body_sum    = '0;
    logic [15:0] csum_stored = '0;
    logic [4:0]  order_sel   = '0;
    logic        party_mode  = 1'b0;

    t_out_item decoded_words [$];
    t_out_item want_item;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int stuck_cycles = 0;

    int err_count     = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int checks_seen   = 0;
    int checks_passed = 0;
    int records_ended = 0;

    function automatic t_out_item decode_word(input logic [15:0] w, input logic mark);
        t_out_item  r;
        logic [7:0] pos;
        int         rel;
        int         blk;
        int         dst;
        logic [4:0] t;
        pos = mark ? 8'd0 : next_pos;
        if (pos > PARTY_LAST) begin
            pos = 8'd0;
        end
        r = '{out_word: w, out_index: pos, check_valid: 1'b0, check_ok: 1'b0,
              record_end: 1'b0};
        if (pos < HEAD_WORDS) begin
            if (pos == 8'd0) begin
                key_reg  = {16'h0000, w};
                body_sum = '0;
            end else if (pos == KEY_HI_POS) begin
                key_reg   = {w, key_reg[15:0]};
                gen_state = key_reg;
                order_sel = key_reg[17:13];
            end else if (pos == CSUM_POS) begin
                csum_stored = w;
            end
        end else if (pos <= BODY_LAST) begin
            rel = int'(pos) - int'(HEAD_WORDS);
            blk = rel / int'(BLK_WORDS);
            t   = order_sel % ORDER_MOD;
            dst = -1;
            for (int i = 0; i < 4; i++) begin
                if (dst < 0 && int'(ORDER_TBL[t][i]) == blk) begin
                    dst = i;
                end
            end
            gen_state   = gen_state * LCG_MUL + LCG_ADD;
            r.out_word  = w ^ gen_state[31:16];
            body_sum    = body_sum + r.out_word;
            r.out_index = 8'(int'(HEAD_WORDS) + int'(BLK_WORDS) * dst
                             + rel % int'(BLK_WORDS));
            if (pos == BODY_LAST) begin
                r.check_valid = 1'b1;
                r.check_ok    = (body_sum == csum_stored);
                r.record_end  = !party_mode;
            end
        end else begin
            // The tail restarts the generator from the key
            if (pos == TAIL_FIRST) begin
                gen_state = key_reg;
            end
            gen_state  = gen_state * LCG_MUL + LCG_ADD;
            r.out_word = w ^ gen_state[31:16];
            if (pos == PARTY_LAST) begin
                r.record_end = 1'b1;
            end
        end
        next_pos = r.record_end ? 8'd0 : pos + 8'd1;
        return r;
    endfunction

    // Returns at the rising edge at which the word is transferred.
    task automatic send_word(input logic [15:0] w, input logic mark);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(99) < 5) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{data_word: w, record_start: mark};
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        decoded_words.push_back(decode_word(w, mark));
        words_sent++;
    endtask

    // fill: 0 random body, 1 all zeros, 2 all ones
    task automatic send_record(input logic [31:0] key, input int n_words,
                               input bit sum_match, input bit mark, input int fill);
        logic [15:0] words [0:129];
        logic [31:0] lcg;
        logic [15:0] sum;
        for (int i = 0; i < 130; i++) begin
            words[i] = (fill == 1) ? 16'h0000 : (fill == 2) ? 16'hFFFF : 16'($urandom);
        end
        lcg = key;
        sum = '0;
        for (int i = int'(HEAD_WORDS); i <= int'(BODY_LAST); i++) begin
            lcg = lcg * LCG_MUL + LCG_ADD;
            sum = sum + (words[i] ^ lcg[31:16]);
        end
        words[0] = key[15:0];
        words[1] = key[31:16];
        words[3] = sum_match ? sum : 16'($urandom);
        for (int i = 0; i < n_words; i++) begin
            send_word(words[i], mark && (i == 0));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_party(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        party_mode  = value;
    endtask

    function automatic logic [31:0] key_with_order(input logic [4:0] sel);
        logic [31:0] key;
        key        = $urandom;
        key[17:13] = sel;
        return key;
    endfunction

    task automatic test_plain_records();
        write_party(1'b0);
        send_record(32'h0000_0000, 116, 1'b1, 1'b1, 1);
        send_record(32'hFFFF_FFFF, 116, 1'b0, 1'b1, 2);
        send_record(key_with_order(5'd5), 116, 1'b1, 1'b1, 0);
        wait_drained();
    endtask

    task automatic test_tail_records();
        write_party(1'b1);
        send_record(key_with_order(5'd24), 130, 1'b1, 1'b1, 0);
        // Next record starts from the wrapped position without a start mark
        send_record(key_with_order(5'd27), 130, 1'b0, 1'b0, 0);
        wait_drained();
    endtask

    task automatic test_start_mark();
        send_record(key_with_order(5'd13), 60, 1'b1, 1'b1, 0);
        send_record(key_with_order(5'd30), 125, 1'b1, 1'b1, 0);
        send_record(key_with_order(5'd18), 130, 1'b1, 1'b1, 0);
        send_word(16'($urandom), 1'b1);
        send_word(16'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_length_change();
        // Setting cleared while the tail is in progress: the tail still completes
        send_record(key_with_order(5'd9), 120, 1'b1, 1'b1, 0);
        wait_drained();
        write_party(1'b0);
        repeat (10) send_word(16'($urandom), 1'b0);
        wait_drained();
        // Setting cleared in the body: the record ends after the body
        write_party(1'b1);
        send_record(key_with_order(5'd22), 100, 1'b1, 1'b1, 0);
        wait_drained();
        write_party(1'b0);
        repeat (16) send_word(16'($urandom), 1'b0);
        send_word(16'($urandom), 1'b0);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_record(key_with_order(5'd31), 116, 1'b1, 1'b1, 0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        send_record(key_with_order(5'd16), 40, 1'b0, 1'b1, 0);
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_records();
        int kind;
        int n_recs;
        bit mark;
        n_recs = 0;
        while (words_sent < ITEM_TARGET) begin
            if (n_recs % 4 == 3) begin
                wait_drained();
                write_party(1'($urandom_range(1)));
            end
            if ($urandom_range(9) == 0) begin
                tx_idle_on = !tx_idle_on;
                rx_idle_on = !rx_idle_on;
            end
            kind = $urandom_range(99);
            if (kind < 65) begin
                mark = (next_pos != 8'd0) || $urandom_range(1);
                send_record(key_with_order(5'(n_recs)), party_mode ? 130 : 116,
                            1'($urandom_range(1)), mark, 0);
            end else if (kind < 85) begin
                send_record(key_with_order(5'(n_recs)), $urandom_range(5, 129),
                            1'($urandom_range(1)), 1'b1, 0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(16'($urandom), $urandom_range(9) == 0);
                end
            end
            n_recs++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_idle_on && ($urandom_range(99) < 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (decoded_words.size() == 0) begin
                $error("result transfer with nothing expected: %h", o_out_item);
                err_count++;
            end else begin
                want_item = decoded_words.pop_front();
                if (o_out_item.out_word !== want_item.out_word) begin
                    $error("out_word: expected %h, got %h",
                           want_item.out_word, o_out_item.out_word);
                    err_count++;
                end
                if (o_out_item.out_index !== want_item.out_index) begin
                    $error("out_index: expected %0d, got %0d",
                           want_item.out_index, o_out_item.out_index);
                    err_count++;
                end
                if (o_out_item.check_valid !== want_item.check_valid) begin
                    $error("check_valid: expected %b, got %b",
                           want_item.check_valid, o_out_item.check_valid);
                    err_count++;
                end
                if (o_out_item.check_ok !== want_item.check_ok) begin
                    $error("check_ok: expected %b, got %b",
                           want_item.check_ok, o_out_item.check_ok);
                    err_count++;
                end
                if (o_out_item.record_end !== want_item.record_end) begin
                    $error("record_end: expected %b, got %b",
                           want_item.record_end, o_out_item.record_end);
                    err_count++;
                end
                if (want_item.check_valid) begin
                    checks_seen++;
                    checks_passed += want_item.check_ok;
                end
                records_ended += want_item.record_end;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: timeout after %0d cycles without a transfer", stuck_cycles);
            $display("tb_top: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_records();
        test_tail_records();
        test_start_mark();
        test_length_change();
        test_back_to_back();
        test_output_backpressure();
        test_random_records();
        $display("tb_top: %0d words decoded and %0d results compared", words_sent,
                 results_seen);
        $display("tb_top: %0d checksum flags (%0d matching), %0d records completed",
                 checks_seen, checks_passed, records_ended);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lcgkd_pkg.sv
rtl/lcgkd_core.sv
rtl/lcg_keystream_record_decoder_top.sv
test/tb_top.sv
